@@ rtl/core/vstm_pkg.sv @@
`timescale 1ns / 1ps
// vstm_pkg: shared constants, codes and taper tables for the volume step
// and taper map. No dependencies.
package vstm_pkg;

  // command codes
  localparam logic [1:0] CMD_ABS  = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;
  localparam logic [1:0] CMD_DOWN = 2'd2;
  localparam int unsigned CMD_BITS = 2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_MIN   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_MAX   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_STEP   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAPER_MODE = 2'd3;

  // register reset values
  localparam int unsigned AXIS_MIN_RST = 0;
  localparam int unsigned AXIS_MAX_RST = 1936;
  localparam int unsigned KEY_STEP_RST = 135;
  localparam logic        TAPER_RST    = 1'b0;

  // percent fields and taper table
  localparam int unsigned PCT_BITS     = 7;
  localparam int unsigned TAPER_POINTS = 11;
  localparam int unsigned IDX_BITS     = 4;
  localparam logic [PCT_BITS-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_BITS-1:0] PCT_TENTH = 7'(TAPER_POINTS - 1);

  typedef logic [PCT_BITS-1:0] pct_t;

  localparam pct_t TAPER_LIN [TAPER_POINTS] =
    '{7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100};
  localparam pct_t TAPER_AUD [TAPER_POINTS] =
    '{7'd0, 7'd42, 7'd55, 7'd60, 7'd66, 7'd72, 7'd77, 7'd83, 7'd89, 7'd94, 7'd100};

  // taper point lookup; out-of-range index reads the last point
  function automatic pct_t taper_pt(input logic mode, input logic [IDX_BITS-1:0] idx);
    logic [IDX_BITS-1:0] i;
    i = (idx > IDX_BITS'(TAPER_POINTS - 1)) ? IDX_BITS'(TAPER_POINTS - 1) : idx;
    return mode ? TAPER_AUD[i] : TAPER_LIN[i];
  endfunction

endpackage

@@ rtl/core/vstm_ifs.sv @@
`timescale 1ns / 1ps
// Request channel interfaces for the volume step and taper map.
// Depends on vstm_pkg.
interface vstm_in_if #(
  parameter int RAW_BITS = 12
);
  import vstm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] cmd;
  logic [RAW_BITS-1:0] pot_reading;

  modport source (output valid, output cmd, output pot_reading, input ready);
  modport sink   (input valid, input cmd, input pot_reading, output ready);
endinterface

interface vstm_out_if #(
  parameter int RAW_BITS = 12
);
  import vstm_pkg::*;
  logic                valid;
  logic                ready;
  logic [RAW_BITS-1:0] volume_raw;
  logic [PCT_BITS-1:0] drive_pct;
  logic [PCT_BITS-1:0] display_pct;

  modport source (output valid, output volume_raw, output drive_pct, output display_pct,
                  input ready);
  modport sink   (input valid, input volume_raw, input drive_pct, input display_pct,
                  output ready);
endinterface

@@ rtl/core/vstm_muldiv.sv @@
`timescale 1ns / 1ps
// vstm_muldiv: bit-serial (a*b + c) / d with a 7-bit quotient and a RAW_BITS-wide remainder.
// Depends on vstm_pkg. Caller guarantees the quotient fits 7 bits.
module vstm_muldiv #(
  parameter int RAW_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [RAW_BITS-1:0]           a,
  input  logic [vstm_pkg::PCT_BITS-1:0] b,
  input  logic [RAW_BITS-1:0]           c,
  input  logic [RAW_BITS-1:0]           d,
  output logic                          done,
  output logic [vstm_pkg::PCT_BITS-1:0] quo,
  output logic [RAW_BITS-1:0]           rem
);
  import vstm_pkg::*;

  localparam int PB = PCT_BITS;
  localparam int NW = RAW_BITS + PB;
  localparam int CNT_BITS = $clog2(PB);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PB - 1);

  typedef enum logic [1:0] {AS_IDLE, AS_MUL, AS_SUM, AS_DIV} as_state_t;

  as_state_t           state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [RAW_BITS-1:0] a_r, a_nxt, c_r, c_nxt, d_r, d_nxt, rem_r, rem_nxt;
  logic [PB-1:0]       b_r, b_nxt, quo_r, quo_nxt;
  logic [NW-1:0]       acc_r, acc_nxt;
  logic                done_r, done_nxt;

  logic [NW-1:0]       sum;
  logic [RAW_BITS:0]   trial;
  logic                ge;

  assign sum   = acc_r + NW'(c_r);
  assign trial = {rem_r, acc_r[PB-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    case (state_r)
      AS_IDLE: begin
        if (start) begin
          a_nxt     = a;
          b_nxt     = b;
          c_nxt     = c;
          d_nxt     = d;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = AS_MUL;
        end
      end
      AS_MUL: begin
        // MSB-first shift-add over b
        acc_nxt = {acc_r[NW-2:0], 1'b0} + (b_r[PB-1] ? NW'(a_r) : '0);
        b_nxt   = {b_r[PB-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = AS_SUM;
        end
      end
      AS_SUM: begin
        // high part is already below d since the quotient fits PB bits
        acc_nxt   = sum;
        rem_nxt   = sum[NW-1:PB];
        cnt_nxt   = '0;
        state_nxt = AS_DIV;
      end
      AS_DIV: begin
        rem_nxt = ge ? RAW_BITS'(trial - {1'b0, d_r}) : trial[RAW_BITS-1:0];
        quo_nxt = {quo_r[PB-2:0], ge};
        acc_nxt = {acc_r[NW-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          done_nxt  = 1'b1;
          state_nxt = AS_IDLE;
        end
      end
      default: begin
        state_nxt = AS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/volume_step_and_taper_map_core.sv @@
`timescale 1ns / 1ps
// Volume step and taper map core. Raw values at either axis end settle without
// division; other values run three passes through the one bit-serial mul/div
// unit (7 multiply steps, 7 divide steps). A new request is accepted only once
// the previous result has been loaded into the output register.
// Reset (synchronous, rst_n low): registers to 0/1936/135/linear, volume 968.
module volume_step_and_taper_map_core #(
  parameter int RAW_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  vstm_in_if.sink                           in_ch,
  vstm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [vstm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [RAW_BITS-1:0]               cfg_wdata
);
  import vstm_pkg::*;

  localparam logic [RAW_BITS-1:0] CUR_RST = RAW_BITS'((AXIS_MIN_RST + AXIS_MAX_RST) / 2);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DRIVE, ST_W_DRIVE, ST_IDX, ST_W_IDX, ST_INTERP, ST_W_INTERP, ST_DONE
  } st_t;

  // config registers
  logic [RAW_BITS-1:0] axis_min_r, axis_min_nxt, axis_max_r, axis_max_nxt;
  logic [RAW_BITS-1:0] key_step_r, key_step_nxt;
  logic                taper_r, taper_nxt;

  // sequencer state and working registers
  st_t                 state_r, state_nxt;
  logic [RAW_BITS-1:0] cur_r, cur_nxt;
  logic [RAW_BITS-1:0] off_r, off_nxt, span_r, span_nxt, part_r, part_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  pct_t                drive_r, drive_nxt, disp_r, disp_nxt;

  // output stage
  logic                out_valid_r, out_valid_nxt;
  logic [RAW_BITS-1:0] out_raw_r, out_raw_nxt;
  pct_t                out_drive_r, out_drive_nxt, out_disp_r, out_disp_nxt;

  // next raw volume from the request
  logic                in_fire;
  logic [RAW_BITS+1:0] up_sum;
  logic [RAW_BITS:0]   dn_lim;
  logic [RAW_BITS-1:0] raw_new;

  // mul/div unit
  logic                md_start, md_done;
  logic [RAW_BITS-1:0] md_a, md_c, md_rem;
  pct_t                md_b, md_quo;
  pct_t                tap_lo, tap_hi;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign up_sum = {2'b00, cur_r} + {2'b00, key_step_r};
  assign dn_lim = {1'b0, axis_min_r} + {1'b0, key_step_r};

  always_comb begin
    raw_new = cur_r;
    case (in_ch.cmd)
      CMD_ABS: begin
        // upper clamp wins when the axis is inverted
        if (in_ch.pot_reading > axis_max_r) begin
          raw_new = axis_max_r;
        end else if (in_ch.pot_reading < axis_min_r) begin
          raw_new = axis_min_r;
        end else begin
          raw_new = in_ch.pot_reading;
        end
      end
      CMD_UP: begin
        raw_new = (up_sum <= {2'b00, axis_max_r}) ? up_sum[RAW_BITS-1:0] : axis_max_r;
      end
      CMD_DOWN: begin
        raw_new = ({1'b0, cur_r} >= dn_lim) ? RAW_BITS'(cur_r - key_step_r) : axis_min_r;
      end
      default: begin
        raw_new = cur_r;  // unused code holds the volume
      end
    endcase
  end

  // table points around the current segment
  assign tap_lo = taper_pt(taper_r, idx_r);
  assign tap_hi = taper_pt(taper_r, IDX_BITS'(idx_r + 1'b1));

  // operand select: drive = (off*100 + span/2)/span,
  // segment = off*10 / span, interp = ((hi-lo)*part + span/2)/span
  always_comb begin
    md_start = 1'b0;
    md_a     = off_r;
    md_b     = PCT_FULL;
    md_c     = span_r >> 1;
    case (state_r)
      ST_DRIVE: begin
        md_start = 1'b1;
      end
      ST_IDX: begin
        md_start = 1'b1;
        md_b     = PCT_TENTH;
        md_c     = '0;
      end
      ST_INTERP: begin
        md_start = 1'b1;
        md_a     = part_r;
        md_b     = tap_hi - tap_lo;
      end
      default: begin
        md_start = 1'b0;
      end
    endcase
  end

  vstm_muldiv #(
    .RAW_BITS (RAW_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .c     (md_c),
    .d     (span_r),
    .done  (md_done),
    .quo   (md_quo),
    .rem   (md_rem)
  );

  always_comb begin
    axis_min_nxt  = axis_min_r;
    axis_max_nxt  = axis_max_r;
    key_step_nxt  = key_step_r;
    taper_nxt     = taper_r;
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    off_nxt       = off_r;
    span_nxt      = span_r;
    part_nxt      = part_r;
    idx_nxt       = idx_r;
    drive_nxt     = drive_r;
    disp_nxt      = disp_r;
    out_valid_nxt = out_valid_r;
    out_raw_nxt   = out_raw_r;
    out_drive_nxt = out_drive_r;
    out_disp_nxt  = out_disp_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_MIN:   axis_min_nxt = cfg_wdata;
        REG_AXIS_MAX:   axis_max_nxt = cfg_wdata;
        REG_KEY_STEP:   key_step_nxt = cfg_wdata;
        REG_TAPER_MODE: taper_nxt    = cfg_wdata[0];
        default: begin
        end
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cur_nxt  = raw_new;
          off_nxt  = raw_new - axis_min_r;
          span_nxt = axis_max_r - axis_min_r;
          // axis ends settle without division; covers a degenerate axis too
          if (raw_new >= axis_max_r) begin
            drive_nxt = PCT_FULL;
            disp_nxt  = taper_pt(taper_r, IDX_BITS'(TAPER_POINTS - 1));
            state_nxt = ST_DONE;
          end else if (raw_new <= axis_min_r) begin
            drive_nxt = '0;
            disp_nxt  = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DRIVE;
          end
        end
      end
      ST_DRIVE:  state_nxt = ST_W_DRIVE;
      ST_W_DRIVE: begin
        if (md_done) begin
          drive_nxt = md_quo;
          state_nxt = ST_IDX;
        end
      end
      ST_IDX:    state_nxt = ST_W_IDX;
      ST_W_IDX: begin
        if (md_done) begin
          idx_nxt   = (md_quo > PCT_BITS'(TAPER_POINTS - 2)) ?
                      IDX_BITS'(TAPER_POINTS - 2) : md_quo[IDX_BITS-1:0];
          part_nxt  = md_rem;
          state_nxt = ST_INTERP;
        end
      end
      ST_INTERP: state_nxt = ST_W_INTERP;
      ST_W_INTERP: begin
        if (md_done) begin
          disp_nxt  = tap_lo + md_quo;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = cur_r;
          out_drive_nxt = drive_r;
          out_disp_nxt  = disp_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_min_r  <= RAW_BITS'(AXIS_MIN_RST);
      axis_max_r  <= RAW_BITS'(AXIS_MAX_RST);
      key_step_r  <= RAW_BITS'(KEY_STEP_RST);
      taper_r     <= TAPER_RST;
      state_r     <= ST_IDLE;
      cur_r       <= CUR_RST;
      out_valid_r <= 1'b0;
    end else begin
      axis_min_r  <= axis_min_nxt;
      axis_max_r  <= axis_max_nxt;
      key_step_r  <= key_step_nxt;
      taper_r     <= taper_nxt;
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    off_r       <= off_nxt;
    span_r      <= span_nxt;
    part_r      <= part_nxt;
    idx_r       <= idx_nxt;
    drive_r     <= drive_nxt;
    disp_r      <= disp_nxt;
    out_raw_r   <= out_raw_nxt;
    out_drive_r <= out_drive_nxt;
    out_disp_r  <= out_disp_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.volume_raw  = out_raw_r;
  assign out_ch.drive_pct   = out_drive_r;
  assign out_ch.display_pct = out_disp_r;

`ifndef NO_ASSERTIONS
  // the mul/div unit only finishes while the sequencer waits on it
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == ST_W_DRIVE || state_r == ST_W_IDX || state_r == ST_W_INTERP))
    else $error("mul/div finished outside a wait state");

  // a new result is only loaded from the done state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");

  // both percents stay within 0..100
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_r <= PCT_FULL && out_disp_r <= PCT_FULL))
    else $error("percent out of range");
`endif

endmodule
